>>> hw/rtl/base64_stream_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define B64D_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define B64D_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder package
// Widths, character codes, result types, character decode and count helpers.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int OUT_COUNT_W = 16;
    localparam int MAX_RESULTS = 3;
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);
    localparam int QLVL_W      = $clog2(QDEPTH + 1);

    localparam logic [31:0] OUT_COUNT_MAX = 32'h0000_FFFF;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;
    localparam logic [7:0] LOWER_BIAS   = 8'd71;
    localparam logic [7:0] DIGIT_BIAS   = 8'd4;

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   is_error;
        logic                   last_of_message;
        logic [OUT_COUNT_W-1:0] decoded_count;
    } t_result;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [1:0]                num;
    } t_entry;

    // {legal, sextet}
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r = {1'b1, 6'(c - CHAR_UPPER_A)};
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r = {1'b1, 6'(c - LOWER_BIAS)};
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            r = {1'b1, 6'(c + DIGIT_BIAS)};
        end else if (c == CHAR_PLUS) begin
            r = {1'b1, SEXTET_PLUS};
        end else if (c == CHAR_SLASH) begin
            r = {1'b1, SEXTET_SLASH};
        end else if (c == CHAR_PAD) begin
            r = {1'b1, 6'd0};
        end
        return r;
    endfunction

    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + t_count'(1);
    endfunction

    function automatic logic [OUT_COUNT_W-1:0] show_count(input t_count c);
        if (c > t_count'(OUT_COUNT_MAX)) begin
            return '1;
        end
        return OUT_COUNT_W'(c);
    endfunction

endpackage

>>> hw/rtl/base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes a Base64 character stream into bytes, one character per word.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one character and a message end
// flag per word. Output channel: o_out_valid / i_out_stall carry one result
// per word: a decoded byte, an error flag, a last-of-message flag and the
// saturating byte count of the message.
// Throughput: one character per cycle sustained while the receiver takes
// results. A group of four characters makes at most three results, so the
// output side keeps up. The first result of a character passes the character
// register and then the result queue before it reaches the output; its other
// results follow one per cycle while the receiver does not stall.
// The decoded entries sit in a four-entry result queue; o_in_stall rises when
// the queue could not take the entry of one more character.
// While the receiver stalls, the head result holds and the queue fills, then
// the input stalls. Illegal groups give one error word; the rest of that
// message is dropped. A message ending mid-group gives one error word.
// Reset clears the group state, the count and the queue; no stall at reset.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_message_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_is_error,
    output logic        o_last_of_message,
    output logic [15:0] o_decoded_count
);

    logic    accept;
    logic    push;
    logic    block;
    t_entry  entry;
    t_result result;

    assign o_in_stall = block;
    assign accept     = i_in_valid && !block;

    b64d_group_decoder u_decoder (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_char_in     (i_char_in),
        .i_message_end (i_message_end),
        .o_push        (push),
        .o_entry       (entry)
    );

    b64d_result_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .o_block  (block),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (result)
    );

    assign o_data_byte       = result.data_byte;
    assign o_is_error        = result.is_error;
    assign o_last_of_message = result.last_of_message;
    assign o_decoded_count   = result.decoded_count;

endmodule

>>> hw/rtl/b64d_group_decoder.sv
// ----------------------------------------------------------------------------
// Base64 group decoder
// Character register, group state and the decode of one character into an
// entry of up to three results.
// ----------------------------------------------------------------------------
module b64d_group_decoder
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_in,
    input  logic       i_message_end,
    output logic       o_push,
    output t_entry     o_entry
);

    logic       r_vld;
    logic [7:0] r_char;
    logic       r_end;

    logic [5:0] r_sext [3];
    logic [1:0] r_pos;
    logic       r_illegal;
    logic       r_third_pad;
    logic       r_discard;
    t_count     r_count;

    logic [5:0] n_sext [3];
    logic [1:0] n_pos;
    logic       n_illegal;
    logic       n_third_pad;
    logic       n_discard;
    t_count     n_count;

    logic [6:0] dec;
    logic       legal;
    logic [5:0] v;
    logic       is_pad;
    logic       has1;
    logic       has2;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    t_count     c1;
    t_count     c2;
    t_count     c3;
    t_result    err_res;

    always_comb begin
        dec    = char_to_sextet(r_char);
        legal  = dec[6];
        v      = dec[5:0];
        is_pad = (r_char == CHAR_PAD);
        has1   = !r_third_pad;
        has2   = !is_pad;
        b0     = {r_sext[0], r_sext[1][5:4]};
        b1     = {r_sext[1][3:0], r_sext[2][5:2]};
        b2     = {r_sext[2][1:0], v};
        c1     = sat_inc(r_count);
        c2     = sat_inc(c1);
        c3     = sat_inc(c2);

        err_res.data_byte       = 8'd0;
        err_res.is_error        = 1'b1;
        err_res.last_of_message = r_end;
        err_res.decoded_count   = show_count(r_count);

        n_sext      = r_sext;
        n_pos       = r_pos;
        n_illegal   = r_illegal;
        n_third_pad = r_third_pad;
        n_discard   = r_discard;
        n_count     = r_count;
        o_push      = 1'b0;
        o_entry     = '0;

        if (r_vld) begin
            if (r_discard) begin
                o_push = 1'b0;
            end else if (r_pos != POS_FOURTH) begin
                case (r_pos)
                    POS_FIRST:  n_sext[0] = v;
                    POS_SECOND: n_sext[1] = v;
                    POS_THIRD: begin
                        n_sext[2]   = v;
                        n_third_pad = is_pad;
                    end
                    default: n_sext[0] = r_sext[0];
                endcase
                n_illegal = r_illegal | !legal;
                n_pos     = r_pos + 2'd1;
                if (r_end) begin
                    o_push         = 1'b1;
                    o_entry.res[0] = err_res;
                    o_entry.num    = 2'd1;
                end
            end else begin
                o_push = 1'b1;
                if (r_illegal || !legal) begin
                    o_entry.res[0] = err_res;
                    o_entry.num    = 2'd1;
                    n_discard      = !r_end;
                end else begin
                    o_entry.res[0].data_byte       = b0;
                    o_entry.res[0].is_error        = 1'b0;
                    o_entry.res[0].last_of_message = r_end && !has1 && !has2;
                    o_entry.res[0].decoded_count   = show_count(c1);
                    o_entry.res[1].data_byte       = has1 ? b1 : b2;
                    o_entry.res[1].is_error        = 1'b0;
                    o_entry.res[1].last_of_message = r_end && !(has1 && has2);
                    o_entry.res[1].decoded_count   = show_count(c2);
                    o_entry.res[2].data_byte       = b2;
                    o_entry.res[2].is_error        = 1'b0;
                    o_entry.res[2].last_of_message = r_end;
                    o_entry.res[2].decoded_count   = show_count(c3);
                    o_entry.num = 2'd1 + 2'(has1) + 2'(has2);
                    n_count = (has1 && has2) ? c3 : ((has1 || has2) ? c2 : c1);
                end
                n_sext      = '{6'd0, 6'd0, 6'd0};
                n_pos       = POS_FIRST;
                n_illegal   = 1'b0;
                n_third_pad = 1'b0;
            end

            if (r_end) begin
                n_sext      = '{6'd0, 6'd0, 6'd0};
                n_pos       = POS_FIRST;
                n_illegal   = 1'b0;
                n_third_pad = 1'b0;
                n_discard   = 1'b0;
                n_count     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= 1'b0;
            r_sext      <= '{6'd0, 6'd0, 6'd0};
            r_pos       <= POS_FIRST;
            r_illegal   <= 1'b0;
            r_third_pad <= 1'b0;
            r_discard   <= 1'b0;
            r_count     <= '0;
        end else begin
            r_vld       <= i_accept;
            r_sext      <= n_sext;
            r_pos       <= n_pos;
            r_illegal   <= n_illegal;
            r_third_pad <= n_third_pad;
            r_discard   <= n_discard;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_char <= i_char_in;
            r_end  <= i_message_end;
        end
    end

endmodule

>>> hw/rtl/b64d_result_queue.sv
// ----------------------------------------------------------------------------
// Base64 result queue
// Holds decoded entries and hands their results out one word at a time.
// ----------------------------------------------------------------------------
module b64d_result_queue
    import b64d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    output logic    o_block,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    t_entry            r_mem [QDEPTH];
    logic [QAW-1:0]    r_wp;
    logic [QAW-1:0]    r_rp;
    logic [QLVL_W-1:0] r_level;
    logic [1:0]        r_sel;

    t_entry            head;
    logic              take;
    logic              pop;
    logic [QLVL_W:0]   level_ahead;

    always_comb begin
        head    = r_mem[r_rp];
        o_valid = (r_level != '0);
        case (r_sel)
            2'd0:    o_result = head.res[0];
            2'd1:    o_result = head.res[1];
            2'd2:    o_result = head.res[2];
            default: o_result = head.res[0];
        endcase
        take        = o_valid && !i_stall;
        pop         = take && (r_sel == head.num - 2'd1);
        level_ahead = (QLVL_W + 1)'(r_level) + (QLVL_W + 1)'(i_push);
        o_block     = (level_ahead >= (QLVL_W + 1)'(QDEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
            r_sel   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (pop) begin
                r_rp  <= r_rp + QAW'(1);
                r_sel <= 2'd0;
            end else if (take) begin
                r_sel <= r_sel + 2'd1;
            end
            r_level <= r_level + QLVL_W'(i_push) - QLVL_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

>>> hw/rtl/b64d_checker.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder port checker
// Watches the top level ports over time.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_top_macros.svh"

module b64d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_data_byte,
    input logic        o_is_error,
    input logic        o_last_of_message,
    input logic [15:0] o_decoded_count
);

    `B64D_ASSERT_IMP(a_error_zero, o_out_valid && o_is_error, o_data_byte == 8'd0, "error word carries data")

    `B64D_ASSERT_IMP(a_count_nonzero, o_out_valid && !o_is_error, o_decoded_count != 16'd0, "byte word with zero count")

    `B64D_ASSERT_IMP(a_count_step, (o_out_valid && !i_out_stall && !o_is_error && !o_last_of_message) ##1 (o_out_valid && !o_is_error), (o_decoded_count == $past(o_decoded_count) + 16'd1) || ((o_decoded_count == 16'hFFFF) && ($past(o_decoded_count) == 16'hFFFF)), "byte count did not advance by one")

    `B64D_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_data_byte) && $stable(o_is_error) && $stable(o_decoded_count), "stalled output word changed")

endmodule

bind base64_stream_decoder_top b64d_checker u_checker (.*);

>>> bench/b64d_stream_checker.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder checker
// Watches both channels of the decoder. Each character taken on the input
// channel is decoded here into the words the block should produce: one to
// three bytes per legal group, or one error word for an illegal group or a
// message that ends mid-group. Words leaving the output channel are compared
// field by field, in order, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module b64d_stream_checker
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_message_end,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_error,
    input  logic        i_last_of_message,
    input  logic [15:0] i_decoded_count,
    output int          o_fault_count,
    output int          o_pending,
    output int          o_words_checked,
    output int          o_error_words
);
    timeunit 1ns;
    timeprecision 1ps;

    t_result    decoded_due[$];
    logic [5:0] held [3];
    logic [1:0] grp_pos;
    logic       grp_bad;
    logic       third_pad;
    logic       skipping;
    t_count     byte_tally;
    int         faults = 0;
    int         checked = 0;
    int         err_words = 0;

    // {legal, sextet}
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return {1'b1, 6'(c - CHAR_UPPER_A)};
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return {1'b1, 6'(c - CHAR_LOWER_A + 8'd26)};
        end
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            return {1'b1, 6'(c - CHAR_DIGIT_0 + 8'd52)};
        end
        if (c == CHAR_PLUS) begin
            return {1'b1, SEXTET_PLUS};
        end
        if (c == CHAR_SLASH) begin
            return {1'b1, SEXTET_SLASH};
        end
        if (c == CHAR_PAD) begin
            return {1'b1, 6'd0};
        end
        return 7'd0;
    endfunction

    task automatic clear_group();
        held[0]   = '0;
        held[1]   = '0;
        held[2]   = '0;
        grp_pos   = POS_FIRST;
        grp_bad   = 1'b0;
        third_pad = 1'b0;
    endtask

    task automatic start_message();
        clear_group();
        skipping   = 1'b0;
        byte_tally = '0;
    endtask

    task automatic push_word(input logic [7:0] data, input logic err, input logic last);
        t_result w;
        w.data_byte       = data;
        w.is_error        = err;
        w.last_of_message = last;
        w.decoded_count   = (byte_tally > t_count'(OUT_COUNT_MAX)) ? '1
                                                                   : OUT_COUNT_W'(byte_tally);
        decoded_due.push_back(w);
    endtask

    task automatic emit_byte(input logic [7:0] data, input logic last);
        if (byte_tally != '1) begin
            byte_tally = byte_tally + t_count'(1);
        end
        push_word(data, 1'b0, last);
    endtask

    task automatic decode_char(input logic [7:0] c, input logic e);
        logic [6:0] lv;
        logic       ok;
        logic [5:0] v;
        logic       b1_on;
        logic       b2_on;
        lv = sextet_of(c);
        ok = lv[6];
        v  = lv[5:0];
        if (skipping) begin
            if (e) begin
                start_message();
            end
            return;
        end
        if (grp_pos != POS_FOURTH) begin
            held[grp_pos] = v;
            if (!ok) begin
                grp_bad = 1'b1;
            end
            if (grp_pos == POS_THIRD) begin
                third_pad = (c == CHAR_PAD);
            end
            grp_pos = grp_pos + 2'd1;
            if (e) begin
                push_word(8'h00, 1'b1, 1'b1);
            end
        end else begin
            if (grp_bad || !ok) begin
                push_word(8'h00, 1'b1, e);
                if (!e) begin
                    skipping = 1'b1;
                end
            end else begin
                b1_on = !third_pad;
                b2_on = (c != CHAR_PAD);
                emit_byte({held[0], held[1][5:4]}, e && !b1_on && !b2_on);
                if (b1_on) begin
                    emit_byte({held[1][3:0], held[2][5:2]}, e && !b2_on);
                end
                if (b2_on) begin
                    emit_byte({held[2][1:0], v}, e);
                end
            end
            clear_group();
        end
        if (e) begin
            start_message();
        end
    endtask

    task automatic log_fault(input string why, input t_result want, input t_result got);
        faults++;
        if (faults <= 10) begin
            $display("%0t: %s: expected byte=%02h err=%0b last=%0b count=%0d, got byte=%02h err=%0b last=%0b count=%0d",
                     $time, why, want.data_byte, want.is_error, want.last_of_message,
                     want.decoded_count, got.data_byte, got.is_error, got.last_of_message,
                     got.decoded_count);
        end
    endtask

    task automatic check_word();
        t_result got;
        t_result want;
        string   bad;
        got.data_byte       = i_data_byte;
        got.is_error        = i_is_error;
        got.last_of_message = i_last_of_message;
        got.decoded_count   = i_decoded_count;
        checked++;
        if (got.is_error === 1'b1) begin
            err_words++;
        end
        if (decoded_due.size() == 0) begin
            log_fault("word with nothing pending", '0, got);
            return;
        end
        want = decoded_due.pop_front();
        bad  = "";
        if (got.data_byte !== want.data_byte) begin
            bad = {bad, " data_byte"};
        end
        if (got.is_error !== want.is_error) begin
            bad = {bad, " is_error"};
        end
        if (got.last_of_message !== want.last_of_message) begin
            bad = {bad, " last_of_message"};
        end
        if (got.decoded_count !== want.decoded_count) begin
            bad = {bad, " decoded_count"};
        end
        if (bad != "") begin
            log_fault({"mismatch in", bad}, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_message();
            decoded_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_word();
            end
            if (i_in_valid && !i_in_stall) begin
                decode_char(i_char_in, i_message_end);
            end
        end
        o_fault_count   <= faults;
        o_pending       <= decoded_due.size();
        o_words_checked <= checked;
        o_error_words   <= err_words;
    end

endmodule

>>> bench/tb_base64_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Drives character words into the decoder: a short directed set covering the
// alphabet extremes, padding in the first, third and fourth positions, illegal
// groups, discarded characters and truncated messages, then random messages
// that are mostly well formed with some broken ones and noise. Both sides idle
// in random bursts, with one long receiver hold-off that backs up the input channel.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DIRECTED     = 28;
    localparam int RANDOM_CHARS = 440;
    localparam int CALM_TAIL    = 60;

    typedef enum int {MSG_TRUNCATED, MSG_ILLEGAL, MSG_NOISE} t_msg_kind;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  in_char   = 8'h00;
    logic        in_end    = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  data_byte;
    logic        is_error;
    logic        last_flag;
    logic [15:0] dec_count;

    bit idle_on  = 1'b0;
    bit hold_req = 1'b0;
    int sent_chars = 0;
    int messages = 0;
    int cycle_count = 0;
    int fault_count;
    int pending;
    int words_checked;
    int error_words;

    always #4 clk = ~clk;

    base64_stream_decoder_top dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_char_in         (in_char),
        .i_message_end     (in_end),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_data_byte       (data_byte),
        .o_is_error        (is_error),
        .o_last_of_message (last_flag),
        .o_decoded_count   (dec_count)
    );

    b64d_stream_checker u_stream_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_char_in         (in_char),
        .i_message_end     (in_end),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_data_byte       (data_byte),
        .i_is_error        (is_error),
        .i_last_of_message (last_flag),
        .i_decoded_count   (dec_count),
        .o_fault_count     (fault_count),
        .o_pending         (pending),
        .o_words_checked   (words_checked),
        .o_error_words     (error_words)
    );

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        if (v < 6'd26) begin
            return CHAR_UPPER_A + 8'(v);
        end
        if (v < 6'd52) begin
            return CHAR_LOWER_A + 8'(v - 6'd26);
        end
        if (v < SEXTET_PLUS) begin
            return CHAR_DIGIT_0 + 8'(v - 6'd52);
        end
        return (v == SEXTET_PLUS) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    function automatic logic [7:0] illegal_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(128, 255));
            1:       return 8'($urandom_range(0, CHAR_PLUS - 1));
            2:       return 8'($urandom_range(CHAR_UPPER_Z + 1, CHAR_LOWER_A - 1));
            default: return 8'($urandom_range(CHAR_LOWER_Z + 1, 127));
        endcase
    endfunction

    function automatic logic [7:0] any_char();
        case ($urandom_range(0, 9))
            0, 1:    return 8'($urandom_range(0, 255));
            2:       return CHAR_PAD;
            default: return alpha_char(6'($urandom_range(0, 63)));
        endcase
    endfunction

    // hold the word until taken
    task automatic send_char(input logic [7:0] c, input logic e);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        in_end   <= e;
        do @(posedge clk); while (in_stall);
        sent_chars++;
        if (e) begin
            messages++;
        end
    endtask

    task automatic send_text(input string s, input logic end_last);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], end_last && i == s.len() - 1);
        end
    endtask

    task automatic send_valid_message();
        int         groups;
        int         pads;
        logic [7:0] c;
        groups = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
        pads   = $urandom_range(0, 2);
        for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 4; k++) begin
                c = alpha_char(6'($urandom_range(0, 63)));
                if (g == groups - 1 && ((k == 3 && pads != 0) || (k == 2 && pads == 2))) begin
                    c = CHAR_PAD;
                end
                send_char(c, g == groups - 1 && k == 3);
            end
        end
    endtask

    task automatic send_broken_message();
        t_msg_kind  kind;
        int         n;
        int         bad_at;
        logic [7:0] c;
        kind = t_msg_kind'($urandom_range(0, 2));
        case (kind)
            MSG_TRUNCATED: n = 4 * $urandom_range(0, 3) + $urandom_range(1, 3);
            MSG_ILLEGAL:   n = 4 * $urandom_range(1, 4) + $urandom_range(0, 6);
            default:       n = $urandom_range(1, 14);
        endcase
        bad_at = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) begin
            case (kind)
                MSG_TRUNCATED: c = ($urandom_range(0, 5) == 0) ? CHAR_PAD
                                                               : alpha_char(6'($urandom_range(0, 63)));
                MSG_ILLEGAL:   c = (i == bad_at) ? illegal_char()
                                                 : alpha_char(6'($urandom_range(0, 63)));
                default:       c = any_char();
            endcase
            send_char(c, i == n - 1);
        end
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_base64_stream_decoder_top: done, errors");
        $finish;
    end

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        idle_on = 1'b1;
        send_text("AZ/z09+/QQ==", 1'b1);
        send_text("=A=BQQ=", 1'b1);
        send_char(8'h00, 1'b0);
        send_char(CHAR_UPPER_A, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CHAR_SLASH, 1'b0);
        send_text("Q", 1'b1);
        send_char(8'h80, 1'b0);
        send_text("AB=", 1'b1);

        hold_req = 1'b1;
        while (sent_chars < DIRECTED + RANDOM_CHARS) begin
            idle_on = (sent_chars < DIRECTED + RANDOM_CHARS - CALM_TAIL)
                      && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 9) < 7) begin
                send_valid_message();
            end else begin
                send_broken_message();
            end
        end
        idle_on = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d characters in %0d messages, with a long output hold-off",
                 sent_chars, messages);
        $display("checked %0d result words, %0d of them error words", words_checked, error_words);
        if (fault_count == 0) begin
            $display("tb_base64_stream_decoder_top: done, clean");
        end else begin
            $display("tb_base64_stream_decoder_top: done, errors");
        end
        $finish;
    end

endmodule
